[sv/srmc_pkg.sv]
// Shared types and constants for the speed ramp motor command block.
// No dependencies; imported by srmc_serial_sub and speed_ramp_motor_command.
`default_nettype none

package srmc_pkg;

    // Field widths fixed by the interface
    localparam int DELAY_W   = 14;
    localparam int REQ_W     = 10;
    localparam int SPEED_W   = 4;
    localparam int CODE_W    = 4;
    localparam int CHAN_W    = 2;
    localparam int DIR_W     = 2;
    localparam int QUOT_W    = 3;
    localparam int NUM_W     = REQ_W + QUOT_W;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 14;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_DELAY  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DECEL_DELAY  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DECEL_FOLLOW = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_SPEED    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_SEL   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_SEL  = 3'd5;

    localparam logic [REQ_W-1:0] MAX_SPEED_RESET = 10'd127;

    // Item kinds and directions
    localparam logic MODE_TICK    = 1'b0;
    localparam logic MODE_COMMAND = 1'b1;

    localparam logic [DIR_W-1:0] DIR_REVERSE = 2'd0;
    localparam logic [DIR_W-1:0] DIR_FORWARD = 2'd1;
    localparam logic [DIR_W-1:0] DIR_ESTOP   = 2'd2;

    localparam logic [CODE_W-1:0] CODE_BRAKE = 4'd8;

    // Status of the serial subtractor
    typedef struct packed {
        logic busy;
        logic no_borrow;
        logic nonzero;
    } t_sub_stat;

endpackage

`default_nettype wire

[sv/srmc_serial_sub.sv]
// Bit-serial subtractor: computes a - b one bit per cycle, LSB first.
// Depends on srmc_pkg for the status struct.
`default_nettype none

module srmc_serial_sub #(
    parameter int WIDTH = 16
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_start,
    input  wire logic [WIDTH-1:0]    i_a,
    input  wire logic [WIDTH-1:0]    i_b,
    output srmc_pkg::t_sub_stat      o_stat,
    output logic      [WIDTH-1:0]    o_diff
);
    import srmc_pkg::*;

    localparam int CNT_W = $clog2(WIDTH + 1);

    logic [WIDTH-1:0] r_a;
    logic [WIDTH-1:0] r_b;
    logic [CNT_W-1:0] r_cnt;
    logic             r_borrow;
    logic             r_nz;

    logic             w_a0;
    logic             w_b0;
    logic             w_dbit;
    logic             n_borrow;

    assign w_a0     = r_a[0];
    assign w_b0     = r_b[0];
    assign w_dbit   = w_a0 ^ w_b0 ^ r_borrow;
    assign n_borrow = (~w_a0 & w_b0) | (~(w_a0 ^ w_b0) & r_borrow);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= '0;
            r_borrow <= 1'b0;
            r_nz     <= 1'b0;
        end else if (i_start) begin
            r_cnt    <= CNT_W'(WIDTH);
            r_borrow <= 1'b0;
            r_nz     <= 1'b0;
        end else if (r_cnt != '0) begin
            r_cnt    <= r_cnt - 1'b1;
            r_borrow <= n_borrow;
            r_nz     <= r_nz | w_dbit;
        end
    end

    // difference bits enter at the top as the minuend drains out the bottom
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a <= i_a;
            r_b <= i_b;
        end else if (r_cnt != '0) begin
            r_a <= {w_dbit, r_a[WIDTH-1:1]};
            r_b <= {1'b0, r_b[WIDTH-1:1]};
        end
    end

    assign o_stat.busy      = (r_cnt != '0);
    assign o_stat.no_borrow = ~r_borrow;
    assign o_stat.nonzero   = r_nz;
    assign o_diff           = r_a;

endmodule

`default_nettype wire

[sv/speed_ramp_motor_command.sv]
// Speed ramp motor command: turns speed commands and 1 ms ticks into drive codes.
// Depends on srmc_pkg and srmc_serial_sub.
//
// One item is worked on at a time. A tick that finds current and target speed
// equal only advances the elapsed time. Any other tick runs a bit-serial compare
// and subtract of the elapsed time against the ramp delay, and may produce a beat.
// A speed command scales the request with a 3-step restoring divider; an emergency
// stop zeroes both speeds and produces a beat.
// A held output beat stalls the block only when another beat is ready behind it.
`default_nettype none

module speed_ramp_motor_command #(
    parameter int ELAPSED_WIDTH = 16
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // configuration write port
    input  wire logic                              i_cfg_we,
    input  wire logic [srmc_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [srmc_pkg::CFG_DAT_W-1:0]    i_cfg_wdata,
    // input stream
    input  wire logic                              i_s_tvalid,
    output logic                                   o_s_tready,
    input  wire logic [15:0]                       i_s_tdata,  // direction[1:0], speed_request[11:2]
    input  wire logic                              i_s_tuser,  // mode
    // output stream
    output logic                                   o_m_tvalid,
    input  wire logic                              i_m_tready,
    output logic [7:0]                             o_m_tdata   // drive_code[3:0], output_port[4],
                                                               // channel_number[6:5]
);
    import srmc_pkg::*;

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_DIV     = 3'd1;
    localparam logic [2:0] ST_CMD_END = 3'd2;
    localparam logic [2:0] ST_SUB     = 3'd3;
    localparam logic [2:0] ST_EMIT    = 3'd4;

    // configuration
    logic [DELAY_W-1:0] r_accel_delay;
    logic [DELAY_W-1:0] r_decel_delay;
    logic               r_decel_follow;
    logic [REQ_W-1:0]   r_max_speed;
    logic               r_output_sel;
    logic [CHAN_W-1:0]  r_channel_sel;

    // ramp state
    logic [2:0]               r_state;
    logic [SPEED_W-1:0]       r_cur_speed;
    logic [SPEED_W-1:0]       r_tgt_speed;
    logic [ELAPSED_WIDTH-1:0] r_elapsed;
    logic                     r_up;
    logic                     r_dir_rev;
    logic [NUM_W-1:0]         r_rem;
    logic [QUOT_W-1:0]        r_quot;
    logic [1:0]               r_div_step;
    logic [CODE_W-1:0]        r_res_code;

    // output register
    logic                     r_m_valid;
    logic [7:0]               r_m_data;

    logic                     w_accept;
    logic                     w_mode;
    logic [DIR_W-1:0]         w_dir;
    logic [REQ_W-1:0]         w_req;
    logic [REQ_W-1:0]         w_req_clamped;
    logic [NUM_W-1:0]         w_num;
    logic [NUM_W-1:0]         w_div_sh;
    logic                     w_div_ge;
    logic [QUOT_W-1:0]        w_scaled;
    logic [SPEED_W-1:0]       w_cmd_tgt;
    logic [DELAY_W-1:0]       w_decel_eff;
    logic [ELAPSED_WIDTH-1:0] w_elapsed_inc;
    logic                     w_tick_up;
    logic [DELAY_W-1:0]       w_tick_delay;
    logic                     w_sub_start;
    logic                     w_out_free;
    t_sub_stat                w_sub_stat;
    logic [ELAPSED_WIDTH-1:0] w_sub_diff;

    assign w_accept   = i_s_tvalid & o_s_tready;
    assign w_mode     = i_s_tuser;
    assign w_dir      = i_s_tdata[1:0];
    assign w_req      = i_s_tdata[11:2];
    assign o_s_tready = (r_state == ST_IDLE);
    assign w_out_free = ~r_m_valid | i_m_tready;

    assign w_req_clamped = (w_req > r_max_speed) ? r_max_speed : w_req;
    // req * 7 as req * 8 - req
    assign w_num = {w_req_clamped, 3'b000} - {3'b000, w_req_clamped};

    always_comb begin
        case (r_div_step)
            2'd2:    w_div_sh = {1'b0, r_max_speed, 2'b00};
            2'd1:    w_div_sh = {2'b00, r_max_speed, 1'b0};
            default: w_div_sh = {3'b000, r_max_speed};
        endcase
    end
    assign w_div_ge = (r_rem >= w_div_sh);

    // a zero full scale would divide by zero; force the speed to zero
    assign w_scaled  = (r_max_speed == '0) ? '0 : r_quot;
    assign w_cmd_tgt = r_dir_rev ? (SPEED_W'(0) - {1'b0, w_scaled}) : {1'b0, w_scaled};

    assign w_decel_eff   = r_decel_follow ? r_accel_delay : r_decel_delay;
    assign w_elapsed_inc = (r_elapsed == '1) ? r_elapsed : r_elapsed + 1'b1;
    assign w_tick_up     = ($signed(r_cur_speed) < $signed(r_tgt_speed));
    assign w_tick_delay  = w_tick_up ? r_accel_delay : w_decel_eff;
    assign w_sub_start   = w_accept & (w_mode == MODE_TICK) & (r_cur_speed != r_tgt_speed);

    srmc_serial_sub #(
        .WIDTH (ELAPSED_WIDTH)
    ) u_sub (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_sub_start),
        .i_a     (w_elapsed_inc),
        .i_b     ({{(ELAPSED_WIDTH - DELAY_W){1'b0}}, w_tick_delay}),
        .o_stat  (w_sub_stat),
        .o_diff  (w_sub_diff)
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accel_delay  <= '0;
            r_decel_delay  <= '0;
            r_decel_follow <= 1'b0;
            r_max_speed    <= MAX_SPEED_RESET;
            r_output_sel   <= 1'b0;
            r_channel_sel  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ACCEL_DELAY:  r_accel_delay  <= i_cfg_wdata[DELAY_W-1:0];
                CFG_DECEL_DELAY:  r_decel_delay  <= i_cfg_wdata[DELAY_W-1:0];
                CFG_DECEL_FOLLOW: r_decel_follow <= i_cfg_wdata[0];
                CFG_MAX_SPEED:    r_max_speed    <= i_cfg_wdata[REQ_W-1:0];
                CFG_OUTPUT_SEL:   r_output_sel   <= i_cfg_wdata[0];
                CFG_CHANNEL_SEL:  r_channel_sel  <= i_cfg_wdata[CHAN_W-1:0];
                default: ;
            endcase
        end
    end

    // control and ramp state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cur_speed <= '0;
            r_tgt_speed <= '0;
            r_elapsed   <= '0;
            r_m_valid   <= 1'b0;
        end else begin
            // load a new beat, or drop the one just taken
            if (r_state == ST_EMIT && w_out_free) begin
                r_m_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        if (w_mode == MODE_COMMAND) begin
                            r_elapsed <= '0;
                            if (w_dir == DIR_REVERSE || w_dir == DIR_FORWARD) begin
                                r_state <= ST_DIV;
                            end else begin
                                // emergency stop, unused direction too
                                r_cur_speed <= '0;
                                r_tgt_speed <= '0;
                                r_state     <= ST_EMIT;
                            end
                        end else begin
                            r_elapsed <= w_elapsed_inc;
                            if (r_cur_speed != r_tgt_speed) begin
                                r_state <= ST_SUB;
                            end
                        end
                    end
                end
                ST_DIV: begin
                    if (r_div_step == 2'd0) begin
                        r_state <= ST_CMD_END;
                    end
                end
                ST_CMD_END: begin
                    r_tgt_speed <= w_cmd_tgt;
                    if (w_cmd_tgt == r_cur_speed) begin
                        r_state <= ST_EMIT;
                    end else if (($signed(r_cur_speed) < $signed(w_cmd_tgt))
                                 ? (r_accel_delay == '0) : (w_decel_eff == '0)) begin
                        r_cur_speed <= w_cmd_tgt;
                        r_state     <= ST_EMIT;
                    end else begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_SUB: begin
                    if (!w_sub_stat.busy) begin
                        // step only when elapsed strictly exceeds the delay
                        if (w_sub_stat.no_borrow && w_sub_stat.nonzero) begin
                            r_cur_speed <= r_up ? r_cur_speed + 1'b1 : r_cur_speed - 1'b1;
                            r_elapsed   <= w_sub_diff;
                            r_state     <= ST_EMIT;
                        end else begin
                            r_state <= ST_IDLE;
                        end
                    end
                end
                ST_EMIT: begin
                    if (w_out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_dir_rev  <= (w_dir == DIR_REVERSE);
                r_rem      <= w_num;
                r_quot     <= '0;
                r_div_step <= 2'd2;
                r_up       <= w_tick_up;
                r_res_code <= CODE_BRAKE;
            end
            ST_DIV: begin
                if (w_div_ge) begin
                    r_rem <= r_rem - w_div_sh;
                end
                r_quot     <= {r_quot[QUOT_W-2:0], w_div_ge};
                r_div_step <= r_div_step - 1'b1;
            end
            ST_CMD_END: begin
                // signed speed in four bits is already the drive code
                r_res_code <= w_cmd_tgt;
            end
            ST_SUB: begin
                r_res_code <= r_up ? r_cur_speed + 1'b1 : r_cur_speed - 1'b1;
            end
            ST_EMIT: begin
                if (w_out_free) begin
                    r_m_data <= {1'b0, r_channel_sel, r_output_sel, r_res_code};
                end
            end
            default: ;
        endcase
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;

    // speeds stay within -7..7, never the lone four-bit value -8
    a_cur_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cur_speed != 4'b1000)
        else $error("current speed out of range");

    a_tgt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tgt_speed != 4'b1000)
        else $error("target speed out of range");

    a_estop_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_mode == MODE_COMMAND && w_dir[1])
        |=> (r_cur_speed == '0 && r_tgt_speed == '0 && r_state == ST_EMIT))
        else $error("emergency stop did not clear speeds");

    a_sub_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sub_start |=> (r_state == ST_SUB && w_sub_stat.busy))
        else $error("serial subtractor not running for tick");

    a_tick_no_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_mode == MODE_TICK && r_cur_speed == r_tgt_speed)
        |=> (r_state == ST_IDLE && $stable(r_cur_speed)))
        else $error("tick stepped with speeds equal");

endmodule

`default_nettype wire
